FILE: hdl/bsa_pkg.sv
// ============================================================================
// bsa_pkg - shared definitions for the bitmap slot allocator
// Request, status and register index codes, field widths and defaults.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    // Default number of slots in one memory block
    localparam int DEF_NUM_SLOTS = 64;

    // Fixed field widths of the request and result items
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int START_W = 7;

    // Slots examined per group during the search
    localparam int GRP_W  = 8;
    localparam int GRP_IW = 3;

    // Reset values of the fill limits
    localparam logic [CNT_W-1:0] UPPER_RESET = 7'd64;
    localparam logic [CNT_W-1:0] LOWER_RESET = 7'd0;

    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NONE_BELOW = 2'd2,
        STATUS_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic
    {
        CFG_UPPER = 1'b0,
        CFG_LOWER = 1'b1
    } cfg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic load;     // capture an accepted request item
        logic scan;     // register the per-group search results
        logic commit;   // update bitmap and count, load the result register
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bsa_ctrl.sv
// ============================================================================
// bsa_ctrl - request sequencer for the bitmap slot allocator
// Steps each request through capture, group scan and commit, and owns the
// result valid flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bsa_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit_ok;

    // Commit only when the result register is empty or being emptied
    assign commit_ok = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_ok)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/bsa_dpath.sv
// ============================================================================
// bsa_dpath - bitmap, fill count and search logic of the slot allocator
// Holds the occupancy bitmap, the fill limits and the result register;
// the downward search runs as a registered group stage and a group select.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bsa_dpath
#(
    parameter int NUM_SLOTS = bsa_pkg::DEF_NUM_SLOTS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bsa_pkg::dp_cmd_t              cmd,
    input  wire logic                          req_type,
    input  wire logic [bsa_pkg::START_W-1:0]   search_start,
    input  wire logic [bsa_pkg::IDX_W-1:0]     release_slot,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_idx,
    input  wire logic [bsa_pkg::CNT_W-1:0]     cfg_value,
    output logic [1:0]                         status,
    output logic [bsa_pkg::IDX_W-1:0]          granted_slot,
    output logic                               underfull,
    output logic [bsa_pkg::CNT_W-1:0]          fill_count
);

    localparam int NUM_GRP = (NUM_SLOTS + bsa_pkg::GRP_W - 1) / bsa_pkg::GRP_W;
    localparam int PAD_W   = NUM_GRP * bsa_pkg::GRP_W;
    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int USED_W  = 1 << SLOT_W;

    // Captured request
    logic                          req_reg;
    logic [bsa_pkg::START_W-1:0]   start_reg;
    logic [bsa_pkg::IDX_W-1:0]     rel_reg;

    // Allocator state and limits
    logic [NUM_SLOTS-1:0]          map_reg;
    logic [NUM_SLOTS-1:0]          map_next;
    logic [bsa_pkg::CNT_W-1:0]     occ_reg;
    logic [bsa_pkg::CNT_W-1:0]     occ_next;
    logic [bsa_pkg::CNT_W-1:0]     upper_reg;
    logic [bsa_pkg::CNT_W-1:0]     lower_reg;

    // Search stage
    logic [PAD_W-1:0]              cand;
    logic [NUM_GRP-1:0]            grp_any;
    logic [bsa_pkg::GRP_IW-1:0]    grp_idx [NUM_GRP];
    logic [NUM_GRP-1:0]            grp_any_reg;
    logic [bsa_pkg::GRP_IW-1:0]    grp_idx_reg [NUM_GRP];

    // Commit stage
    logic                          found;
    logic [bsa_pkg::IDX_W-1:0]     sel_slot;
    logic [USED_W-1:0]             used_pad;
    logic                          rel_used;
    logic [bsa_pkg::CNT_W-1:0]     occ_dec;
    logic [1:0]                    status_next;
    logic [bsa_pkg::IDX_W-1:0]     grant_next;
    logic                          under_next;
    logic [NUM_SLOTS-1:0]          one_hot_base;

    // Result register
    logic [1:0]                    status_reg;
    logic [bsa_pkg::IDX_W-1:0]     grant_reg;
    logic                          under_reg;
    logic [bsa_pkg::CNT_W-1:0]     count_reg;

    assign one_hot_base = {{(NUM_SLOTS-1){1'b0}}, 1'b1};

    // Free slots lying below the search start
    always_comb
    begin
        cand = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cand[i] = !map_reg[i] && (bsa_pkg::START_W'(i) < start_reg);
        end
    end

    // Highest free slot within each group
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_any[g] = 1'b0;
            grp_idx[g] = '0;
            for (int k = 0; k < bsa_pkg::GRP_W; k++)
            begin
                if (cand[g*bsa_pkg::GRP_W + k])
                begin
                    grp_any[g] = 1'b1;
                    grp_idx[g] = bsa_pkg::GRP_IW'(k);
                end
            end
        end
    end

    // Highest group holding a free slot
    always_comb
    begin
        found    = 1'b0;
        sel_slot = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            if (grp_any_reg[g])
            begin
                found    = 1'b1;
                sel_slot = bsa_pkg::IDX_W'(g * bsa_pkg::GRP_W) +
                           bsa_pkg::IDX_W'(grp_idx_reg[g]);
            end
        end
    end

    // Release check and the count after a free
    assign used_pad = USED_W'(map_reg);
    assign rel_used = ({1'b0, rel_reg} < bsa_pkg::CNT_W'(NUM_SLOTS)) &&
                      used_pad[rel_reg[SLOT_W-1:0]];
    assign occ_dec  = occ_reg - bsa_pkg::CNT_W'(1);

    // Resolve the request
    always_comb
    begin
        map_next    = map_reg;
        occ_next    = occ_reg;
        status_next = bsa_pkg::STATUS_OK;
        grant_next  = '0;
        under_next  = 1'b0;
        if (req_reg == bsa_pkg::REQ_ALLOC)
        begin
            if (occ_reg >= upper_reg)
            begin
                status_next = bsa_pkg::STATUS_FULL;
            end
            else if (!found)
            begin
                status_next = bsa_pkg::STATUS_NONE_BELOW;
            end
            else
            begin
                grant_next = sel_slot;
                map_next   = map_reg | (one_hot_base << sel_slot);
                occ_next   = occ_reg + bsa_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (!rel_used)
            begin
                status_next = bsa_pkg::STATUS_NOT_ALLOC;
            end
            else
            begin
                map_next   = map_reg & ~(one_hot_base << rel_reg);
                occ_next   = occ_dec;
                under_next = (occ_dec <= lower_reg);
            end
        end
    end

    // Capture request, search results and outputs
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            start_reg <= search_start;
            rel_reg   <= release_slot;
        end
        if (cmd.scan)
        begin
            grp_any_reg <= grp_any;
            grp_idx_reg <= grp_idx;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            under_reg  <= under_next;
            count_reg  <= occ_next;
        end
    end

    // Update bitmap, count and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            occ_reg   <= '0;
            upper_reg <= bsa_pkg::UPPER_RESET;
            lower_reg <= bsa_pkg::LOWER_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                map_reg <= map_next;
                occ_reg <= occ_next;
            end
            if (cfg_we)
            begin
                if (cfg_idx == bsa_pkg::CFG_UPPER)
                begin
                    upper_reg <= cfg_value;
                end
                else
                begin
                    lower_reg <= cfg_value;
                end
            end
        end
    end

    assign status       = status_reg;
    assign granted_slot = grant_reg;
    assign underfull    = under_reg;
    assign fill_count   = count_reg;

endmodule

`default_nettype wire

FILE: hdl/bitmap_slot_allocator_core.sv
// ============================================================================
// bitmap_slot_allocator_core - occupancy bitmap allocator for one memory block
// Allocates the nearest free slot below a start position and frees slots.
// ============================================================================
// Usage:
//   Requests arrive on the s_* channel, one item per request; tuser selects
//   allocate or free. Each request produces exactly one result item on m_*.
//   The user must write the fill limits on the cfg_* channel only while no
//   request is in flight (the block does not enforce this); cfg_ready is always high.
// Sequencing:
//   An accepted request is captured, then the scan of 8-slot groups is
//   registered, then the group select and commit load the result register.
//   The controller handles one request at a time and returns to idle after
//   the commit, so a new item is accepted only after the last one commits.
// Stall:
//   The result sits in an output register. The next request is accepted and
//   scanned while it waits; the commit holds until the receiver takes it.
// Reset:
//   All slots free, count zero, upper limit 64, lower limit 0, no result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator_core
#(
    parameter int NUM_SLOTS = bsa_pkg::DEF_NUM_SLOTS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // search_start[6:0], release_slot[12:7], zero
    input  wire logic [0:0]  s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // granted_slot[5:0], underfull[6],
                                        // fill_count[13:7], zero
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    bsa_pkg::dp_cmd_t               cmd;
    logic [1:0]                     status;
    logic [bsa_pkg::IDX_W-1:0]      granted_slot;
    logic                           underfull;
    logic [bsa_pkg::CNT_W-1:0]      fill_count;

    assign cfg_ready = 1'b1;

    // Request sequencer
    bsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // Bitmap and search datapath
    bsa_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (s_tuser[0]),
        .search_start (s_tdata[6:0]),
        .release_slot (s_tdata[12:7]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_value    (cfg_data),
        .status       (status),
        .granted_slot (granted_slot),
        .underfull    (underfull),
        .fill_count   (fill_count)
    );

    // Pack the result item
    assign m_tdata = {2'b00, fill_count, underfull, granted_slot};
    assign m_tuser = status;

endmodule

`default_nettype wire

FILE: hdl/bsa_checker.sv
// ============================================================================
// bsa_checker - port-level checks for the bitmap slot allocator
// Watches the request and result channels of the top level over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bsa_checker
#(
    parameter int NUM_SLOTS = bsa_pkg::DEF_NUM_SLOTS
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A new result only follows a request in flight
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a request");

    // Failed requests grant nothing and never report underfull
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bsa_pkg::STATUS_OK
            |-> m_tdata[6:0] == 7'd0 && m_tdata[13:7] <= 7'(NUM_SLOTS))
        else $error("failed request reports a grant");

endmodule

bind bitmap_slot_allocator_core bsa_checker #(.NUM_SLOTS(NUM_SLOTS)) u_bsa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/bsa_result_checker.sv
// ============================================================================
// bsa_result_checker - result checker for the bitmap slot allocator
// Watches the request, result and register channels, keeps its own copy of
// the occupancy bitmap and the fill limits, and compares each result item
// field by field with the oldest predicted one.
// ============================================================================
`timescale 1ns / 1ps

module bsa_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // search_start[6:0], release_slot[12:7], zero
    input  logic [0:0]  s_tuser,    // req_type[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // granted_slot[5:0], underfull[6],
                                    // fill_count[13:7], zero
    input  logic [1:0]  m_tuser,    // status[1:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef struct packed
    {
        bsa_pkg::status_t status;
        logic [5:0]       slot;
        logic             under;
        logic [6:0]       count;
    } slot_result_t;

    // Shadow of the allocator state and its limits
    logic [63:0]  used_map;
    logic [6:0]   occupied;
    logic [6:0]   upper_limit;
    logic [6:0]   lower_limit;
    slot_result_t expected_results[$];

    // Serve one request against the shadow state and return its outcome
    function automatic slot_result_t serve_request(input bsa_pkg::req_t kind,
                                                   input logic [6:0] start,
                                                   input logic [5:0] rel);
        slot_result_t r;
        int           pos;
        r.status = bsa_pkg::STATUS_OK;
        r.slot   = '0;
        r.under  = 1'b0;
        if (kind == bsa_pkg::REQ_ALLOC)
        begin
            if (occupied >= upper_limit)
                r.status = bsa_pkg::STATUS_FULL;
            else
            begin
                // Start beyond the block saturates to the top slot
                pos = (start > 7'd64) ? 64 : int'(start);
                while (pos > 0 && used_map[pos-1])
                    pos--;
                if (pos == 0)
                    r.status = bsa_pkg::STATUS_NONE_BELOW;
                else
                begin
                    r.slot = 6'(pos - 1);
                    used_map[pos-1] = 1'b1;
                    occupied = occupied + 7'd1;
                end
            end
        end
        else if (!used_map[rel])
            r.status = bsa_pkg::STATUS_NOT_ALLOC;
        else
        begin
            used_map[rel] = 1'b0;
            occupied = occupied - 7'd1;
            r.under = (occupied <= lower_limit);
        end
        r.count = occupied;
        return r;
    endfunction

    // Track register writes, predict on requests, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t got;
        slot_result_t want;
        if (!rst_n)
        begin
            used_map    = '0;
            occupied    = '0;
            upper_limit = bsa_pkg::UPPER_RESET;
            lower_limit = bsa_pkg::LOWER_RESET;
            expected_results.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (bsa_pkg::cfg_idx_t'(cfg_index) == bsa_pkg::CFG_UPPER)
                    upper_limit = cfg_data;
                else
                    lower_limit = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(serve_request(bsa_pkg::req_t'(s_tuser[0]),
                                                         s_tdata[6:0], s_tdata[12:7]));
            if (m_tvalid && m_tready)
            begin
                got.status = bsa_pkg::status_t'(m_tuser);
                got.slot   = m_tdata[5:0];
                got.under  = m_tdata[6];
                got.count  = m_tdata[13:7];
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item: expected none, got status %0d",
                             $time, got.status, " slot %0d underfull %0d count %0d",
                             got.slot, got.under, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.slot != want.slot)
                    begin
                        errors++;
                        $display("%0t: granted_slot expected %0d got %0d",
                                 $time, want.slot, got.slot);
                    end
                    if (got.under != want.under)
                    begin
                        errors++;
                        $display("%0t: underfull expected %0d got %0d",
                                 $time, want.under, got.under);
                    end
                    if (got.count != want.count)
                    begin
                        errors++;
                        $display("%0t: fill_count expected %0d got %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// tb_top - testbench for bitmap_slot_allocator_core
// Drives directed and random allocate and free requests under several fill
// limit settings with random idling on both streams; a checker predicts and
// compares every result item.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 88;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    int errors;
    int outstanding;
    int cycles = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // Limit settings per random phase; -1 picks a random limit
    int ph_upper[NUM_PHASES]  = '{64, 64, 127, 127, 0, 40, 1, -1};
    int ph_lower[NUM_PHASES]  = '{0, 32, 64, 127, 0, 20, 127, -1};
    int ph_alloc[NUM_PHASES]  = '{90, 35, 80, 30, 50, 70, 50, 60};
    bit ph_calm[NUM_PHASES]   = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    always #5 clk = ~clk;

    bitmap_slot_allocator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bsa_result_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request item and hold it until accepted
    task automatic send_request(input bsa_pkg::req_t kind, input logic [6:0] start,
                                input logic [5:0] rel);
        int gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, rel, start};
        do @(posedge clk); while (!s_tready);
    endtask

    // Random request; start mostly at or above the top of the block
    task automatic send_random(input int alloc_pct);
        bsa_pkg::req_t kind;
        logic [6:0]    start;
        int            r;
        kind = ($urandom_range(0, 99) < alloc_pct) ? bsa_pkg::REQ_ALLOC : bsa_pkg::REQ_FREE;
        r = $urandom_range(0, 9);
        if (r < 4)
            start = 7'd64;
        else if (r < 6)
            start = 7'($urandom_range(65, 127));
        else
            start = 7'($urandom_range(0, 63));
        send_request(kind, start, 6'($urandom_range(0, 63)));
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both fill limits back to back
    task automatic write_limits(input logic [6:0] upper, input logic [6:0] lower);
        cfg_valid <= 1'b1;
        cfg_index <= bsa_pkg::CFG_UPPER;
        cfg_data  <= upper;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= bsa_pkg::CFG_LOWER;
        cfg_data  <= lower;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls unless the phase runs calm
    initial
    begin
        int hold;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_calm ? 0 : idle_len();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("bitmap_slot_allocator_core: mismatch");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [6:0] upper;
        logic [6:0] lower;
        rst_n     = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= bsa_pkg::CFG_UPPER;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start at zero, free of an empty slot, top and saturated starts
        write_limits(7'd64, 7'd0);
        send_request(bsa_pkg::REQ_ALLOC, 7'd0, 6'($urandom));
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd5);
        send_request(bsa_pkg::REQ_ALLOC, 7'd64, 6'($urandom));
        send_request(bsa_pkg::REQ_ALLOC, 7'd127, 6'($urandom));
        send_request(bsa_pkg::REQ_ALLOC, 7'd100, 6'($urandom));
        send_request(bsa_pkg::REQ_ALLOC, 7'd1, 6'($urandom));
        // Slot zero taken: nothing below
        send_request(bsa_pkg::REQ_ALLOC, 7'd1, 6'($urandom));
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd63);
        // Double free
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd63);
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd0);
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd62);
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd61);
        drain();

        // Directed: fill limit reached, underfull on free
        write_limits(7'd2, 7'd1);
        send_request(bsa_pkg::REQ_ALLOC, 7'd64, 6'($urandom));
        send_request(bsa_pkg::REQ_ALLOC, 7'd64, 6'($urandom));
        send_request(bsa_pkg::REQ_ALLOC, 7'd64, 6'($urandom));
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd63);
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd62);
        drain();

        // Directed: zero upper limit refuses every allocate
        write_limits(7'd0, 7'd0);
        send_request(bsa_pkg::REQ_ALLOC, 7'd64, 6'($urandom));
        send_request(bsa_pkg::REQ_FREE, 7'($urandom), 6'd10);

        // Random phases over several limit settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            upper = (ph_upper[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(ph_upper[p]);
            lower = (ph_lower[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(ph_lower[p]);
            write_limits(upper, lower);
            tx_calm = ph_calm[p];
            rx_calm = ph_calm[p];
            repeat (PHASE_ITEMS) send_random(ph_alloc[p]);
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("bitmap_slot_allocator_core: match");
        else
            $display("bitmap_slot_allocator_core: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_dpath.sv
hdl/bitmap_slot_allocator_core.sv
hdl/bsa_checker.sv
tb/bsa_result_checker.sv
tb/tb_top.sv
